[hw/rtl/dlbm_pkg.sv]
// dlbm_pkg: shared types and constants for the discrete latch bank mapper
// board decode codes, config register indexes, mirroring codes, decode result struct
// no dependencies
`default_nettype none

package dlbm_pkg;

    // default width of a bank number inside the mapper
    localparam int unsigned BANK_BITS_DEF = 9;
    // internal bank width, wide enough for the widest BANK_BITS
    localparam int unsigned RAW_W  = 12;
    localparam int unsigned OUT_W  = 9;
    localparam int unsigned CFG_IW = 3;
    localparam int unsigned CFG_DW = 16;

    typedef logic [RAW_W-1:0] t_raw;
    typedef logic [OUT_W-1:0] t_bank;

    // config register indexes
    localparam logic [CFG_IW-1:0] CFG_VARIANT     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_LATCH_INIT  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_WIN_LOW     = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_WIN_HIGH    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_BUS_CONF    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_LARGE_PRG   = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_MIRROR_DEF  = 3'd6;

    // request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_POWER = 1'b1;

    // mirroring codes
    localparam logic [1:0] MIR_HORZ = 2'd0;
    localparam logic [1:0] MIR_VERT = 2'd1;
    localparam logic [1:0] MIR_ONEA = 2'd2;
    localparam logic [1:0] MIR_ONEB = 2'd3;

    // board decode codes
    localparam logic [4:0] VAR_FIXED  = 5'd0;
    localparam logic [4:0] VAR_UXROM  = 5'd1;
    localparam logic [4:0] VAR_CNROM  = 5'd2;
    localparam logic [4:0] VAR_AXROM  = 5'd3;
    localparam logic [4:0] VAR_B8     = 5'd4;
    localparam logic [4:0] VAR_B11    = 5'd5;
    localparam logic [4:0] VAR_CPROM  = 5'd6;
    localparam logic [4:0] VAR_B36    = 5'd7;
    localparam logic [4:0] VAR_B38    = 5'd8;
    localparam logic [4:0] VAR_B66    = 5'd9;
    localparam logic [4:0] VAR_B70    = 5'd10;
    localparam logic [4:0] VAR_B78    = 5'd11;
    localparam logic [4:0] VAR_B86    = 5'd12;
    localparam logic [4:0] VAR_B87    = 5'd13;
    localparam logic [4:0] VAR_B89    = 5'd14;
    localparam logic [4:0] VAR_B93    = 5'd15;
    localparam logic [4:0] VAR_B94    = 5'd16;
    localparam logic [4:0] VAR_B97    = 5'd17;
    localparam logic [4:0] VAR_B101   = 5'd18;
    localparam logic [4:0] VAR_B107   = 5'd19;
    localparam logic [4:0] VAR_B113   = 5'd20;
    localparam logic [4:0] VAR_B152   = 5'd21;
    localparam logic [4:0] VAR_B180   = 5'd22;
    localparam logic [4:0] VAR_B184   = 5'd23;
    localparam logic [4:0] VAR_B203   = 5'd24;
    localparam logic [4:0] VAR_B240   = 5'd25;
    localparam logic [4:0] VAR_B241   = 5'd26;
    localparam logic [4:0] VAR_MC65   = 5'd27;
    localparam logic [4:0] VAR_MC11   = 5'd28;

    typedef struct packed {
        t_bank      prg_lo;
        t_bank      prg_hi;
        t_bank      chr_lo;
        t_bank      chr_hi;
        logic [1:0] mirror;
        logic       sticky;
    } t_decode;

endpackage

`default_nettype wire

[hw/rtl/discrete_latch_bank_mapper_core.sv]
// discrete_latch_bank_mapper_core: top level of the discrete latch bank mapper
// input register, latch/mirroring state with board decode, result register
// depends on dlbm_pkg and dlbm_decode
`default_nettype none

// Cartridge bank mapper around one 8-bit latch. Each request is either a CPU
// write (loads the latch when its address lies in the configured window and
// the board has a latch) or a power event (reloads the mirroring and, on a
// board with a latch, the latch from their configured values). Every request
// returns one result with the PRG/CHR banks and mirroring in force after it.
// Throughput is one request per clock while the result side does not stall.
// The accepting edge loads the input register; the result register then loads
// through the latch update and board decode, and the latch, mirroring and
// sticky bit update together with it, so back-to-back requests see each
// other's effect. A stalled result holds the input register, which then
// stalls the input in the same cycle. Configuration writes are always ready
// and must be made while no request is in flight.

module discrete_latch_bank_mapper_core
    import dlbm_pkg::*;
#(
    parameter int unsigned BANK_BITS = BANK_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire logic              i_func,
    input  wire logic [15:0]       i_address,
    input  wire logic [7:0]        i_data,
    input  wire logic [7:0]        i_rom_value,

    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      logic              o_latch_loaded,
    output      logic [OUT_W-1:0]  o_prg_bank_low,
    output      logic [OUT_W-1:0]  o_prg_bank_high,
    output      logic [OUT_W-1:0]  o_chr_bank_low,
    output      logic [OUT_W-1:0]  o_chr_bank_high,
    output      logic [1:0]        o_mirror_mode,

    input  wire logic              i_cfg_valid,
    output      logic              o_cfg_ready,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    // config registers
    logic [4:0]  r_variant;
    logic [7:0]  r_latch_init;
    logic [15:0] r_win_low, r_win_high;
    logic        r_bus_conf, r_large_prg;
    logic [1:0]  r_mirror_def;

    // mapper state
    logic [7:0]  r_latch, n_latch;
    logic [1:0]  r_mirror, n_mirror;
    logic        r_sticky;

    // input register
    logic        r_s1_valid;
    logic        r_s1_func;
    logic [15:0] r_s1_addr;
    logic [7:0]  r_s1_data, r_s1_rom;

    // result register
    logic        r_out_valid;
    logic        r_out_loaded, n_loaded;
    t_decode     r_out_dec, w_dec;

    logic        w_cfg_wr, w_out_free, w_s1_go, w_in_go, w_board;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_s1_go    = r_s1_valid & w_out_free;
    assign o_in_stall = r_s1_valid & ~w_out_free;
    assign w_in_go    = i_in_valid & ~o_in_stall;

    assign w_board = (r_variant inside {[VAR_UXROM:VAR_MC11]});

    always_comb begin
        n_latch  = r_latch;
        n_loaded = 1'b0;
        n_mirror = r_mirror;
        if (r_s1_func == FUNC_POWER) begin
            n_mirror = r_mirror_def;
            if (w_board) begin
                n_latch  = r_latch_init;
                n_loaded = 1'b1;
            end
        end else if (w_board && r_s1_addr >= r_win_low && r_s1_addr <= r_win_high) begin
            n_latch  = r_bus_conf ? (r_s1_data & r_s1_rom) : r_s1_data;
            n_loaded = 1'b1;
        end
    end

    dlbm_decode #(
        .BANK_BITS (BANK_BITS)
    ) u_decode (
        .i_variant   (r_variant),
        .i_large_prg (r_large_prg),
        .i_latch     (n_latch),
        .i_sync      (n_loaded),
        .i_sticky    (r_sticky),
        .i_mirror    (n_mirror),
        .o_dec       (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant    <= VAR_FIXED;
            r_latch_init <= 8'h00;
            r_win_low    <= 16'h8000;
            r_win_high   <= 16'hFFFF;
            r_bus_conf   <= 1'b0;
            r_large_prg  <= 1'b0;
            r_mirror_def <= MIR_HORZ;
            r_latch      <= 8'h00;
            r_mirror     <= MIR_HORZ;
            r_sticky     <= 1'b0;
        end else begin
            if (w_s1_go) begin
                r_latch  <= n_latch;
                r_mirror <= w_dec.mirror;
                r_sticky <= w_dec.sticky;
            end
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    CFG_VARIANT:    r_variant    <= i_cfg_data[4:0];
                    CFG_LATCH_INIT: r_latch_init <= i_cfg_data[7:0];
                    CFG_WIN_LOW:    r_win_low    <= i_cfg_data;
                    CFG_WIN_HIGH:   r_win_high   <= i_cfg_data;
                    CFG_BUS_CONF:   r_bus_conf   <= i_cfg_data[0];
                    CFG_LARGE_PRG:  r_large_prg  <= i_cfg_data[0];
                    CFG_MIRROR_DEF: begin
                        r_mirror_def <= i_cfg_data[1:0];
                        r_mirror     <= i_cfg_data[1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_go) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_go) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_go) begin
            r_s1_func <= i_func;
            r_s1_addr <= i_address;
            r_s1_data <= i_data;
            r_s1_rom  <= i_rom_value;
        end
        if (w_s1_go) begin
            r_out_loaded <= n_loaded;
            r_out_dec    <= w_dec;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_latch_loaded  = r_out_loaded;
    assign o_prg_bank_low  = r_out_dec.prg_lo;
    assign o_prg_bank_high = r_out_dec.prg_hi;
    assign o_chr_bank_low  = r_out_dec.chr_lo;
    assign o_chr_bank_high = r_out_dec.chr_hi;
    assign o_mirror_mode   = r_out_dec.mirror;

    a_latch_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_go |=> $stable(r_latch) && $stable(r_sticky))
        else $error("latch or sticky bit changed without a request");

    a_sticky_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sticky |=> r_sticky)
        else $error("sticky mirror bit cleared");

    a_no_board: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go && !w_board |=> !r_out_loaded && $stable(r_latch))
        else $error("latch loaded on a board without a latch");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall)
        else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire

[hw/rtl/dlbm_decode.sv]
// dlbm_decode: board decode from latch value to PRG/CHR banks and mirroring
// purely combinational, also produces the next mirroring and sticky bit
// depends on dlbm_pkg
`default_nettype none

module dlbm_decode
    import dlbm_pkg::*;
#(
    parameter int unsigned BANK_BITS = BANK_BITS_DEF
) (
    input  wire logic [4:0] i_variant,
    input  wire logic       i_large_prg,
    input  wire logic [7:0] i_latch,
    input  wire logic       i_sync,
    input  wire logic       i_sticky,
    input  wire logic [1:0] i_mirror,
    output      t_decode    o_dec
);

    localparam t_raw BANK_MASK = t_raw'((13'(1) << BANK_BITS) - 13'(1));
    localparam t_raw BANK_LAST = BANK_MASK;

    function automatic t_raw f_ext(input logic [7:0] x);
        f_ext = {4'b0000, x};
    endfunction

    // 32K bank b shows as 2b / 2b+1
    function automatic t_raw f_dbl(input logic [7:0] x);
        f_dbl = {3'b000, x, 1'b0};
    endfunction

    t_raw       w_plo, w_phi, w_clo, w_chi;
    logic       w_mir_ok;
    logic [1:0] w_mir;
    logic       w_sticky;
    logic [7:0] l;

    assign l = i_latch;

    always_comb begin
        w_plo    = t_raw'(0);
        w_phi    = BANK_LAST;
        w_clo    = t_raw'(0);
        w_chi    = t_raw'(1);
        w_mir_ok = 1'b0;
        w_mir    = MIR_HORZ;
        w_sticky = i_sticky;
        case (i_variant)
            VAR_UXROM: begin
                if (i_large_prg) begin
                    w_plo = f_ext({4'b0, l[3:0]});
                end else begin
                    w_plo    = f_ext({5'b0, l[2:0]});
                    w_sticky = i_sticky | (i_sync & l[3]);
                    w_mir_ok = w_sticky;
                    w_mir    = l[3] ? MIR_HORZ : MIR_VERT;
                end
            end
            VAR_CNROM: begin
                w_plo = f_dbl(8'd0);  w_phi = f_dbl(8'd0) | t_raw'(1);
                w_clo = f_dbl(l);     w_chi = f_dbl(l) | t_raw'(1);
            end
            VAR_AXROM: begin
                w_plo    = f_dbl({4'b0, l[3:0]});
                w_phi    = f_dbl({4'b0, l[3:0]}) | t_raw'(1);
                w_mir_ok = 1'b1;
                w_mir    = l[4] ? MIR_ONEB : MIR_ONEA;
            end
            VAR_B8: begin
                w_plo = f_ext({3'b0, l[7:3]});  w_phi = t_raw'(1);
                w_clo = f_dbl({6'b0, l[1:0]});  w_chi = f_dbl({6'b0, l[1:0]}) | t_raw'(1);
            end
            VAR_B11: begin
                w_plo = f_dbl({4'b0, l[3:0]});  w_phi = f_dbl({4'b0, l[3:0]}) | t_raw'(1);
                w_clo = f_dbl({4'b0, l[7:4]});  w_chi = f_dbl({4'b0, l[7:4]}) | t_raw'(1);
            end
            VAR_CPROM: begin
                w_plo = f_dbl(8'd0);  w_phi = f_dbl(8'd0) | t_raw'(1);
                w_clo = t_raw'(0);    w_chi = f_ext({6'b0, l[1:0]});
            end
            VAR_B36, VAR_B66, VAR_B240: begin
                w_plo = f_dbl({4'b0, l[7:4]});  w_phi = f_dbl({4'b0, l[7:4]}) | t_raw'(1);
                w_clo = f_dbl({4'b0, l[3:0]});  w_chi = f_dbl({4'b0, l[3:0]}) | t_raw'(1);
            end
            VAR_B38: begin
                w_plo = f_dbl({6'b0, l[1:0]});  w_phi = f_dbl({6'b0, l[1:0]}) | t_raw'(1);
                w_clo = f_dbl({2'b0, l[7:2]});  w_chi = f_dbl({2'b0, l[7:2]}) | t_raw'(1);
            end
            VAR_B70: begin
                w_plo = f_ext({4'b0, l[7:4]});
                w_clo = f_dbl({4'b0, l[3:0]});  w_chi = f_dbl({4'b0, l[3:0]}) | t_raw'(1);
            end
            VAR_B78: begin
                w_plo    = f_ext({5'b0, l[2:0]});
                w_clo    = f_dbl({4'b0, l[7:4]});
                w_chi    = f_dbl({4'b0, l[7:4]}) | t_raw'(1);
                w_mir_ok = 1'b1;
                w_mir    = l[3] ? MIR_ONEB : MIR_ONEA;
            end
            VAR_B86: begin
                w_plo = f_dbl({6'b0, l[5:4]});
                w_phi = f_dbl({6'b0, l[5:4]}) | t_raw'(1);
                w_clo = f_dbl({5'b0, l[6], l[1:0]});
                w_chi = f_dbl({5'b0, l[6], l[1:0]}) | t_raw'(1);
            end
            VAR_B87: begin
                // chr select bits come in swapped
                w_plo = f_dbl(8'd0);  w_phi = f_dbl(8'd0) | t_raw'(1);
                w_clo = f_dbl({6'b0, l[0], l[1]});
                w_chi = f_dbl({6'b0, l[0], l[1]}) | t_raw'(1);
            end
            VAR_B89: begin
                w_plo    = f_ext({5'b0, l[6:4]});
                w_clo    = f_dbl({4'b0, l[7], l[2:0]});
                w_chi    = f_dbl({4'b0, l[7], l[2:0]}) | t_raw'(1);
                w_mir_ok = 1'b1;
                w_mir    = l[3] ? MIR_ONEB : MIR_ONEA;
            end
            VAR_B93: begin
                w_plo = f_ext({4'b0, l[7:4]});
            end
            VAR_B94: begin
                w_plo = f_ext({2'b0, l[7:2]});
            end
            VAR_B97: begin
                w_plo = BANK_LAST;
                w_phi = f_ext({4'b0, l[3:0]});
                w_clo = f_dbl({6'b0, l[0], l[1]});
                w_chi = f_dbl({6'b0, l[0], l[1]}) | t_raw'(1);
                // only the two middle codes of bits 7..6 drive mirroring
                w_mir_ok = l[7] ^ l[6];
                w_mir    = l[7] ? MIR_VERT : MIR_HORZ;
            end
            VAR_B101: begin
                w_plo = f_dbl(8'd0);  w_phi = f_dbl(8'd0) | t_raw'(1);
                w_clo = f_dbl(l);     w_chi = f_dbl(l) | t_raw'(1);
            end
            VAR_B107: begin
                w_plo = f_dbl({6'b0, l[2:1]});  w_phi = f_dbl({6'b0, l[2:1]}) | t_raw'(1);
                w_clo = f_dbl({5'b0, l[2:0]});  w_chi = f_dbl({5'b0, l[2:0]}) | t_raw'(1);
            end
            VAR_B113: begin
                w_plo = f_dbl({5'b0, l[5:3]});
                w_phi = f_dbl({5'b0, l[5:3]}) | t_raw'(1);
                w_clo = f_dbl({4'b0, l[6], l[2:0]});
                w_chi = f_dbl({4'b0, l[6], l[2:0]}) | t_raw'(1);
            end
            VAR_B152: begin
                w_plo    = f_ext({5'b0, l[6:4]});
                w_clo    = f_dbl({4'b0, l[3:0]});
                w_chi    = f_dbl({4'b0, l[3:0]}) | t_raw'(1);
                w_mir_ok = 1'b1;
                w_mir    = l[7] ? MIR_ONEB : MIR_ONEA;
            end
            VAR_B180: begin
                w_plo = t_raw'(0);
                w_phi = f_ext(l);
            end
            VAR_B184: begin
                w_plo = f_dbl(8'd0);  w_phi = f_dbl(8'd0) | t_raw'(1);
                w_clo = f_ext(l);     w_chi = f_ext({4'b0, l[7:4]});
            end
            VAR_B203: begin
                w_plo = f_ext({6'b0, l[3:2]});  w_phi = f_ext({6'b0, l[3:2]});
                w_clo = f_dbl({6'b0, l[1:0]});  w_chi = f_dbl({6'b0, l[1:0]}) | t_raw'(1);
            end
            VAR_B241: begin
                w_plo = f_dbl(l);  w_phi = f_dbl(l) | t_raw'(1);
            end
            VAR_MC65: begin
                if (l[6]) begin
                    w_plo = f_dbl({4'b0, l[4:1]});
                    w_phi = f_dbl({4'b0, l[4:1]}) | t_raw'(1);
                end else begin
                    w_plo = f_ext({3'b0, l[5:4], l[2:0]});
                    w_phi = f_ext({3'b0, l[5:4], 3'b111});
                end
                w_mir_ok = 1'b1;
                if (l[7]) begin
                    w_mir = l[5] ? MIR_ONEB : MIR_ONEA;
                end else begin
                    w_mir = l[3] ? MIR_HORZ : MIR_VERT;
                end
            end
            VAR_MC11: begin
                w_plo    = f_dbl({5'b0, l[6:4]});
                w_phi    = f_dbl({5'b0, l[6:4]}) | t_raw'(1);
                w_clo    = f_dbl({3'b0, l[6:4], l[1:0]});
                w_chi    = f_dbl({3'b0, l[6:4], l[1:0]}) | t_raw'(1);
                w_mir_ok = 1'b1;
                w_mir    = l[7] ? MIR_VERT : MIR_HORZ;
            end
            default: begin
                // fixed rom and unused codes: bank 0 then last
                w_plo = t_raw'(0);
            end
        endcase
    end

    t_raw w_plo_m, w_phi_m, w_clo_m, w_chi_m;

    // wrap to BANK_BITS, then present the low output bits
    assign w_plo_m = w_plo & BANK_MASK;
    assign w_phi_m = w_phi & BANK_MASK;
    assign w_clo_m = w_clo & BANK_MASK;
    assign w_chi_m = w_chi & BANK_MASK;

    assign o_dec.prg_lo = w_plo_m[OUT_W-1:0];
    assign o_dec.prg_hi = w_phi_m[OUT_W-1:0];
    assign o_dec.chr_lo = w_clo_m[OUT_W-1:0];
    assign o_dec.chr_hi = w_chi_m[OUT_W-1:0];
    assign o_dec.mirror = (i_sync && w_mir_ok) ? w_mir : i_mirror;
    assign o_dec.sticky = w_sticky;

endmodule

`default_nettype wire

[test/discrete_latch_bank_mapper_core_tb.sv]
// discrete_latch_bank_mapper_core_tb: self-checking bench for the latch bank mapper core
// a bank map checker class predicts every result; plain tasks drive requests and config
// depends on dlbm_pkg and discrete_latch_bank_mapper_core

module discrete_latch_bank_mapper_core_tb;
    import dlbm_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 60;
    localparam int PHASE_COUNT    = 32;
    localparam int PHASE_ITEMS    = 19;
    localparam int PRESSURE_PHASE = 8;

    localparam int unsigned BANK_MASK = (1 << BANK_BITS_DEF) - 1;
    localparam int unsigned BANK_LAST = BANK_MASK;

    // top of the unused decode codes
    localparam logic [4:0] VAR_UNUSED_TOP = 5'd31;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [4:0]  variant;
        logic [7:0]  latch_init;
        logic [15:0] win_low;
        logic [15:0] win_high;
        logic        bus_conf;
        logic        large_prg;
        logic [1:0]  mirror_def;
    } t_map_setting;

    typedef struct {
        logic        loaded;
        t_bank       prg_lo;
        t_bank       prg_hi;
        t_bank       chr_lo;
        t_bank       chr_hi;
        logic [1:0]  mirror;
    } t_map_result;

    class bank_map_checker;
        logic [4:0]  cfg_variant;
        logic [7:0]  cfg_latch_init;
        logic [15:0] cfg_win_low;
        logic [15:0] cfg_win_high;
        logic        cfg_bus_conf;
        logic        cfg_large_prg;
        logic [1:0]  cfg_mirror_def;
        logic [7:0]  latch_q;
        logic        sticky_q;
        logic [1:0]  mirror_q;
        int unsigned prg_lo, prg_hi, chr_lo, chr_hi;
        t_map_result expected_maps[$];
        int          errors;

        function new();
            cfg_variant    = VAR_FIXED;
            cfg_latch_init = 8'h00;
            cfg_win_low    = 16'h8000;
            cfg_win_high   = 16'hFFFF;
            cfg_bus_conf   = 1'b0;
            cfg_large_prg  = 1'b0;
            cfg_mirror_def = MIR_HORZ;
            latch_q        = 8'h00;
            sticky_q       = 1'b0;
            mirror_q       = MIR_HORZ;
            errors         = 0;
        endfunction

        function void write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_VARIANT:    cfg_variant    = val[4:0];
                CFG_LATCH_INIT: cfg_latch_init = val[7:0];
                CFG_WIN_LOW:    cfg_win_low    = val;
                CFG_WIN_HIGH:   cfg_win_high   = val;
                CFG_BUS_CONF:   cfg_bus_conf   = val[0];
                CFG_LARGE_PRG:  cfg_large_prg  = val[0];
                CFG_MIRROR_DEF: begin
                    cfg_mirror_def = val[1:0];
                    mirror_q       = val[1:0];
                end
                default: ;
            endcase
        endfunction

        function void set_prg32(int unsigned b);
            prg_lo = (b << 1) & BANK_MASK;
            prg_hi = ((b << 1) | 1) & BANK_MASK;
        endfunction

        function void set_chr8(int unsigned c);
            chr_lo = (c << 1) & BANK_MASK;
            chr_hi = ((c << 1) | 1) & BANK_MASK;
        endfunction

        function void set_prg16(int unsigned lo, int unsigned hi);
            prg_lo = lo & BANK_MASK;
            prg_hi = hi & BANK_MASK;
        endfunction

        // banks from the latch; on a load the mirroring follows too
        function void decode_banks(bit sync);
            logic [7:0]  l;
            bit          mir_set;
            logic [1:0]  mir_val;
            logic [2:0]  bank;
            l       = latch_q;
            mir_set = 1'b0;
            mir_val = MIR_HORZ;
            case (cfg_variant)
                VAR_UXROM: begin
                    if (cfg_large_prg) begin
                        set_prg16(l[3:0], BANK_LAST);
                    end else begin
                        set_prg16(l[2:0], BANK_LAST);
                        if (sync && l[3]) sticky_q = 1'b1;
                        if (sticky_q) begin
                            mir_set = 1'b1;
                            mir_val = l[3] ? MIR_HORZ : MIR_VERT;
                        end
                    end
                    set_chr8(0);
                end
                VAR_CNROM: begin set_chr8(l); set_prg32(0); end
                VAR_AXROM: begin
                    set_prg32(l[3:0]);
                    mir_set = 1'b1;
                    mir_val = l[4] ? MIR_ONEB : MIR_ONEA;
                    set_chr8(0);
                end
                VAR_B8:    begin set_prg16(l[7:3], 1); set_chr8(l[1:0]); end
                VAR_B11:   begin set_prg32(l[3:0]); set_chr8(l[7:4]); end
                VAR_CPROM: begin chr_lo = 0; chr_hi = l[1:0]; set_prg32(0); end
                VAR_B36, VAR_B66, VAR_B240: begin set_prg32(l[7:4]); set_chr8(l[3:0]); end
                VAR_B38:   begin set_prg32(l[1:0]); set_chr8(l[7:2]); end
                VAR_B70:   begin set_prg16(l[7:4], BANK_LAST); set_chr8(l[3:0]); end
                VAR_B78: begin
                    set_prg16(l[2:0], BANK_LAST);
                    set_chr8(l[7:4]);
                    mir_set = 1'b1;
                    mir_val = l[3] ? MIR_ONEB : MIR_ONEA;
                end
                VAR_B86:   begin set_prg32(l[5:4]); set_chr8({l[6], l[1:0]}); end
                VAR_B87:   begin set_prg32(0); set_chr8({l[0], l[1]}); end
                VAR_B89: begin
                    set_prg16(l[6:4], BANK_LAST);
                    set_chr8({l[7], l[2:0]});
                    mir_set = 1'b1;
                    mir_val = l[3] ? MIR_ONEB : MIR_ONEA;
                end
                VAR_B93:   begin set_prg16(l[7:4], BANK_LAST); set_chr8(0); end
                VAR_B94:   begin set_prg16(l[7:2], BANK_LAST); set_chr8(0); end
                VAR_B97: begin
                    set_prg16(BANK_LAST, l[3:0]);
                    // 00 and 11 in the top bits leave mirroring alone
                    if (l[7:6] == 2'b01) begin
                        mir_set = 1'b1;
                        mir_val = MIR_HORZ;
                    end else if (l[7:6] == 2'b10) begin
                        mir_set = 1'b1;
                        mir_val = MIR_VERT;
                    end
                    set_chr8({l[0], l[1]});
                end
                VAR_B101:  begin set_prg32(0); set_chr8(l); end
                VAR_B107:  begin set_prg32(l[2:1]); set_chr8(l[2:0]); end
                VAR_B113:  begin set_prg32(l[5:3]); set_chr8({l[6], l[2:0]}); end
                VAR_B152: begin
                    set_prg16(l[6:4], BANK_LAST);
                    set_chr8(l[3:0]);
                    mir_set = 1'b1;
                    mir_val = l[7] ? MIR_ONEB : MIR_ONEA;
                end
                VAR_B180:  begin set_prg16(0, l); set_chr8(0); end
                VAR_B184:  begin chr_lo = l; chr_hi = l[7:4]; set_prg32(0); end
                VAR_B203:  begin set_prg16(l[3:2], l[3:2]); set_chr8(l[1:0]); end
                VAR_B241:  begin set_chr8(0); set_prg32(l); end
                VAR_MC65: begin
                    if (l[6]) set_prg32(l[4:1]);
                    else set_prg16({l[5:4], l[2:0]}, {l[5:4], 3'b111});
                    set_chr8(0);
                    mir_set = 1'b1;
                    if (l[7]) mir_val = l[5] ? MIR_ONEB : MIR_ONEA;
                    else mir_val = l[3] ? MIR_HORZ : MIR_VERT;
                end
                VAR_MC11: begin
                    bank = l[6:4];
                    set_prg32(bank);
                    set_chr8({bank, l[1:0]});
                    mir_set = 1'b1;
                    mir_val = l[7] ? MIR_VERT : MIR_HORZ;
                end
                default: begin set_prg16(0, BANK_LAST); set_chr8(0); end
            endcase
            if (sync && mir_set) mirror_q = mir_val;
        endfunction

        function void note_request(logic func, logic [15:0] addr, logic [7:0] data,
                                   logic [7:0] rom);
            t_map_result want;
            bit          latch_board;
            bit          loaded;
            latch_board = (cfg_variant >= VAR_UXROM) && (cfg_variant <= VAR_MC11);
            loaded      = 1'b0;
            if (func == FUNC_POWER) begin
                mirror_q = cfg_mirror_def;
                if (latch_board) begin
                    latch_q = cfg_latch_init;
                    loaded  = 1'b1;
                end
            end else if (latch_board && addr >= cfg_win_low && addr <= cfg_win_high) begin
                latch_q = cfg_bus_conf ? (data & rom) : data;
                loaded  = 1'b1;
            end
            decode_banks(loaded);
            want.loaded = loaded;
            want.prg_lo = t_bank'(prg_lo);
            want.prg_hi = t_bank'(prg_hi);
            want.chr_lo = t_bank'(chr_lo);
            want.chr_hi = t_bank'(chr_hi);
            want.mirror = mirror_q;
            expected_maps.push_back(want);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_map_result got);
            t_map_result want;
            if (expected_maps.size() == 0) begin
                $display("%0t unexpected result: expected none, actual prg %0d/%0d chr %0d/%0d",
                         $time, got.prg_lo, got.prg_hi, got.chr_lo, got.chr_hi);
                errors++;
                return;
            end
            want = expected_maps.pop_front();
            check_field("latch_loaded", want.loaded, got.loaded);
            check_field("prg_bank_low", want.prg_lo, got.prg_lo);
            check_field("prg_bank_high", want.prg_hi, got.prg_hi);
            check_field("chr_bank_low", want.chr_lo, got.chr_lo);
            check_field("chr_bank_high", want.chr_hi, got.chr_hi);
            check_field("mirror_mode", want.mirror, got.mirror);
        endfunction

        function int pending();
            return expected_maps.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_func;
    logic [15:0]       i_address;
    logic [7:0]        i_data;
    logic [7:0]        i_rom_value;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_latch_loaded;
    logic [OUT_W-1:0]  o_prg_bank_low;
    logic [OUT_W-1:0]  o_prg_bank_high;
    logic [OUT_W-1:0]  o_chr_bank_low;
    logic [OUT_W-1:0]  o_chr_bank_high;
    logic [1:0]        o_mirror_mode;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;

    bank_map_checker mapper = new();
    t_map_setting    cur_setting;
    t_map_result     seen_map;
    int              send_pct  = 0;
    int              stall_pct = 0;
    bit              hold_request = 1'b0;
    bit              hold_served  = 1'b0;
    int              hold_left    = 0;

    discrete_latch_bank_mapper_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_address       (i_address),
        .i_data          (i_data),
        .i_rom_value     (i_rom_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_latch_loaded  (o_latch_loaded),
        .o_prg_bank_low  (o_prg_bank_low),
        .o_prg_bank_high (o_prg_bank_high),
        .o_chr_bank_low  (o_chr_bank_low),
        .o_chr_bank_high (o_chr_bank_high),
        .o_mirror_mode   (o_mirror_mode),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("status: fail");
        $finish;
    end

    // result side: random stall, plus one long hold-off to back up the pipe
    initial begin : result_sink
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_map.loaded = o_latch_loaded;
            seen_map.prg_lo = o_prg_bank_low;
            seen_map.prg_hi = o_prg_bank_high;
            seen_map.chr_lo = o_chr_bank_low;
            seen_map.chr_hi = o_chr_bank_high;
            seen_map.mirror = o_mirror_mode;
            mapper.check_result(seen_map);
        end
    end

    task automatic set_idle(t_idle_mode mode);
        case (mode)
            IDLE_SEND: begin send_pct = 63; stall_pct = 0; end
            IDLE_RECV: begin send_pct = 0; stall_pct = 63; end
            IDLE_BOTH: begin send_pct = 12; stall_pct = 12; end
            default:   begin send_pct = 0; stall_pct = 0; end
        endcase
    endtask

    // entered and left just after a falling edge; valid stays up for the next request
    task automatic send_request(logic func, logic [15:0] addr, logic [7:0] data,
                                logic [7:0] rom);
        while (send_pct > 0 && $urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_address   <= addr;
        i_data      <= data;
        i_rom_value <= rom;
        do @(posedge i_clk); while (o_in_stall);
        mapper.note_request(func, addr, data, rom);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (mapper.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // leaves cfg valid high so back-to-back writes need no toggle
    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        mapper.write_cfg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic apply_setting(t_map_setting s);
        wait_drain();
        write_reg(CFG_VARIANT, CFG_DW'(s.variant));
        write_reg(CFG_LATCH_INIT, CFG_DW'(s.latch_init));
        write_reg(CFG_WIN_LOW, s.win_low);
        write_reg(CFG_WIN_HIGH, s.win_high);
        write_reg(CFG_BUS_CONF, CFG_DW'(s.bus_conf));
        write_reg(CFG_LARGE_PRG, CFG_DW'(s.large_prg));
        write_reg(CFG_MIRROR_DEF, CFG_DW'(s.mirror_def));
        i_cfg_valid <= 1'b0;
        cur_setting = s;
    endtask

    function automatic t_map_setting make_setting(logic [4:0] variant, logic [7:0] init,
                                                  logic [15:0] wl, logic [15:0] wh,
                                                  logic bc, logic lp, logic [1:0] md);
        t_map_setting s;
        s.variant    = variant;
        s.latch_init = init;
        s.win_low    = wl;
        s.win_high   = wh;
        s.bus_conf   = bc;
        s.large_prg  = lp;
        s.mirror_def = md;
        return s;
    endfunction

    function automatic t_map_setting random_setting(int ph);
        t_map_setting s;
        logic [15:0]  a;
        logic [15:0]  b;
        a = 16'($urandom);
        b = 16'($urandom);
        s.variant = 5'(ph);
        case ($urandom_range(5))
            0: begin s.win_low = 16'h8000; s.win_high = 16'hFFFF; end
            1: begin s.win_low = 16'h0000; s.win_high = 16'hFFFF; end
            2: begin
                s.win_low  = (a < b) ? a : b;
                s.win_high = (a < b) ? b : a;
            end
            3: begin
                // inverted window, no write loads
                s.win_low  = (a > b) ? a : b;
                s.win_high = (a > b) ? b : a;
                if (a == b) begin
                    s.win_low  = 16'hFFFF;
                    s.win_high = 16'h0000;
                end
            end
            4: begin s.win_low = a; s.win_high = a; end
            default: begin s.win_low = 16'h8000; s.win_high = {1'b1, b[14:0]}; end
        endcase
        case (ph % 3)
            0:       s.latch_init = 8'h00;
            1:       s.latch_init = 8'hFF;
            default: s.latch_init = 8'($urandom);
        endcase
        s.bus_conf   = 1'($urandom_range(1));
        s.large_prg  = 1'($urandom_range(1));
        s.mirror_def = 2'($urandom_range(3));
        return s;
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_request();
        int          r;
        logic [15:0] addr;
        logic        func;
        r    = $urandom_range(99);
        func = (r < 6) ? FUNC_POWER : FUNC_WRITE;
        addr = 16'($urandom);
        if (r >= 6 && r < 80 && cur_setting.win_low <= cur_setting.win_high) begin
            addr = cur_setting.win_low
                 + 16'($urandom_range(cur_setting.win_high - cur_setting.win_low));
        end else if (r >= 80 && r < 88) begin
            // window edges and just outside them
            case ($urandom_range(3))
                0:       addr = cur_setting.win_low;
                1:       addr = cur_setting.win_high;
                2:       addr = cur_setting.win_low - 16'd1;
                default: addr = cur_setting.win_high + 16'd1;
            endcase
        end
        send_request(func, addr, random_byte(), random_byte());
    endtask

    initial begin : stimulus
        int ph;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_WRITE;
        i_address   = 16'h0000;
        i_data      = 8'h00;
        i_rom_value = 8'h00;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_VARIANT;
        i_cfg_data  = '0;
        cur_setting = make_setting(VAR_FIXED, 8'h00, 16'h8000, 16'hFFFF, 1'b0, 1'b0, MIR_HORZ);
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);
        set_idle(IDLE_NONE);

        // fixed rom out of reset: nothing loads, power does not reload
        send_request(FUNC_WRITE, 16'h8000, 8'hFF, 8'hFF);
        send_request(FUNC_POWER, 16'h0000, 8'h00, 8'h00);

        // sticky mirror bit, then kept across power
        apply_setting(make_setting(VAR_UXROM, 8'hA5, 16'h8000, 16'hFFFF, 1'b0, 1'b0, MIR_ONEA));
        send_request(FUNC_POWER, 16'h0000, 8'h00, 8'h00);
        send_request(FUNC_WRITE, 16'h8000, 8'h07, 8'h00);
        send_request(FUNC_WRITE, 16'hFFFF, 8'h08, 8'h00);
        send_request(FUNC_WRITE, 16'h7FFF, 8'h00, 8'h00);
        send_request(FUNC_WRITE, 16'hC000, 8'h00, 8'hFF);
        send_request(FUNC_POWER, 16'hFFFF, 8'hFF, 8'hFF);

        // wide prg field with bus conflict
        apply_setting(make_setting(VAR_UXROM, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 1'b1, MIR_VERT));
        send_request(FUNC_WRITE, 16'h0000, 8'hFF, 8'h0F);
        send_request(FUNC_WRITE, 16'hFFFF, 8'hF0, 8'hFF);

        // board 97 mirroring for each top bit pair
        apply_setting(make_setting(VAR_B97, 8'h00, 16'h8000, 16'hFFFF, 1'b0, 1'b0, MIR_ONEB));
        send_request(FUNC_WRITE, 16'h8000, 8'h00, 8'h00);
        send_request(FUNC_WRITE, 16'h9000, 8'h40, 8'h00);
        send_request(FUNC_WRITE, 16'hA000, 8'h80, 8'h00);
        send_request(FUNC_WRITE, 16'hB000, 8'hC0, 8'h00);
        send_request(FUNC_WRITE, 16'hFFFF, 8'hFF, 8'h00);

        // empty window
        apply_setting(make_setting(VAR_CNROM, 8'h3C, 16'h9000, 16'h8FFF, 1'b0, 1'b0, MIR_HORZ));
        send_request(FUNC_WRITE, 16'h9000, 8'hFF, 8'hFF);
        send_request(FUNC_WRITE, 16'h8FFF, 8'h55, 8'hFF);
        send_request(FUNC_POWER, 16'h0000, 8'h00, 8'h00);

        // unused decode code acts as fixed rom
        apply_setting(make_setting(VAR_UNUSED_TOP, 8'hFF, 16'h8000, 16'hFFFF, 1'b0, 1'b0,
                                   MIR_ONEB));
        send_request(FUNC_WRITE, 16'h8000, 8'hFF, 8'hFF);
        send_request(FUNC_POWER, 16'h0000, 8'h00, 8'h00);

        // multicart modes
        apply_setting(make_setting(VAR_MC65, 8'h00, 16'h0000, 16'hFFFF, 1'b0, 1'b0, MIR_VERT));
        send_request(FUNC_WRITE, 16'h0000, 8'hC0, 8'h00);
        send_request(FUNC_WRITE, 16'h4000, 8'h40, 8'hFF);
        send_request(FUNC_WRITE, 16'h8000, 8'h28, 8'h00);
        send_request(FUNC_WRITE, 16'hFFFF, 8'hA0, 8'hFF);

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            apply_setting(random_setting(ph));
            set_idle(t_idle_mode'(ph % 4));
            if (ph == PRESSURE_PHASE) hold_request = 1'b1;
            repeat (PHASE_ITEMS) send_random_request();
        end

        wait_drain();
        if (mapper.pending() != 0) begin
            $display("%0t %0d expected results never arrived", $time, mapper.pending());
            mapper.errors += mapper.pending();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mapper.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
